[design/conv3_pkg.sv]
package conv3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // window edge and tap count
    localparam int WIN  = 3;
    localparam int TAPS = WIN * WIN;

    localparam int PIX_W       = 8;
    localparam int TAP_W       = 8;
    localparam int MASK_W      = WIN * TAP_W;
    localparam int COORD_W     = 10;
    localparam int DIM_REG_W   = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = MASK_W;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = DIM_REG_W'(1024);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_TOP    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_MIDDLE = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_BOTTOM = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH       = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT      = CFG_INDEX_W'(4);

    // signed tap times zero-extended pixel, and the sum of nine of those
    localparam int PROD_W = TAP_W + PIX_W + 1;
    localparam int SUM_W  = PROD_W + 4;

    localparam int OUT_FIFO_DEPTH = 8;

    typedef struct packed {
        logic [PIX_W-1:0]   filtered_value;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic               frame_last;
    } conv3_result_t;

endpackage

[design/image_convolution_3x3.sv]
// 3x3 convolution over a pixel stream in raster order. One pixel is taken per
// clock, sustained while in_stall is low. A pixel whose window is centred on an
// interior pixel gives a result that passes the s1, s2 and s3 registers and
// the output FIFO. The result carries the centre row and column and a flag on
// the last interior centre of the frame. Border pixels give no result. The
// two previous image rows live in one MAX_WIDTH x 16 line RAM that is read at
// the column of the incoming pixel and written back the following cycle, so
// the RAM port pair sets the one-pixel-per-clock rate. Results queue in an
// eight-beat output FIFO. in_stall rises only when that FIFO and the results
// still in the pipe would fill it, so a stalled output does not block input until
// eight results are queued or in flight. There is no clearing pass after reset.
// Mask, width and height are written by the user while the block is idle, which
// it does not enforce; width and height outside [3, MAX] act as the nearest bound.
module image_convolution_3x3 #(
    parameter int MAX_WIDTH  = conv3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = conv3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [conv3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [conv3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [conv3_pkg::PIX_W-1:0]       pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [conv3_pkg::PIX_W-1:0]       filtered_value,
    output logic [conv3_pkg::COORD_W-1:0]     center_row,
    output logic [conv3_pkg::COORD_W-1:0]     center_col,
    output logic                              frame_last
);

    import conv3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DW_A  = $clog2(MAX_WIDTH + 1);
    localparam int DW_B  = $clog2(MAX_HEIGHT + 1);
    localparam int DW_AB = (DW_A > DW_B) ? DW_A : DW_B;
    localparam int DW    = (DW_AB > DIM_REG_W) ? DW_AB : DIM_REG_W;
    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int RES_W = $bits(conv3_result_t);

    // configuration
    logic [MASK_W-1:0]    mask_rows_reg [WIN];
    logic [DIM_REG_W-1:0] width_reg;
    logic [DIM_REG_W-1:0] height_reg;

    // frame position of the next pixel
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [DW-1:0] w_raw;
    logic [DW-1:0] h_raw;
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [DW-1:0] c_ext;
    logic [DW-1:0] r_ext;
    logic [DW-1:0] c_m1;
    logic [DW-1:0] r_m1;
    logic          accept;
    logic          has_result;
    logic          is_last;

    // stage 1: line RAM data arrives
    logic               s1_valid_reg;
    logic               s1_result_reg;
    logic [PIX_W-1:0]   s1_px_reg;
    logic [COL_W-1:0]   s1_addr_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic [COORD_W-1:0] s1_col_reg;
    logic               s1_last_reg;
    logic [2*PIX_W-1:0] line_rd;
    logic [PIX_W-1:0]   up_one;
    logic [PIX_W-1:0]   up_two;

    // stage 2: window holds the full neighborhood
    logic [PIX_W-1:0]   win_reg [TAPS];
    logic               s2_valid_reg;
    logic [COORD_W-1:0] s2_row_reg;
    logic [COORD_W-1:0] s2_col_reg;
    logic               s2_last_reg;
    logic signed [PROD_W-1:0] prod [TAPS];

    // stage 3: products registered
    logic signed [PROD_W-1:0] prod_reg [TAPS];
    logic               s3_valid_reg;
    logic [COORD_W-1:0] s3_row_reg;
    logic [COORD_W-1:0] s3_col_reg;
    logic               s3_last_reg;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]   mag;

    conv3_result_t  push_res;
    conv3_result_t  head_res;
    logic [RES_W-1:0] head_bits;
    logic [CNT_W-1:0] fifo_count;
    logic [CNT_W:0]   occupancy;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                mask_rows_reg[i] <= '0;
            end
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MASK_TOP:    mask_rows_reg[0] <= cfg_data;
                REG_MASK_MIDDLE: mask_rows_reg[1] <= cfg_data;
                REG_MASK_BOTTOM: mask_rows_reg[2] <= cfg_data;
                REG_WIDTH:       width_reg  <= cfg_data[DIM_REG_W-1:0];
                REG_HEIGHT:      height_reg <= cfg_data[DIM_REG_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------- stage 0: accept
    assign w_raw = DW'(width_reg);
    assign h_raw = DW'(height_reg);
    assign w_eff = (w_raw < DW'(WIN)) ? DW'(WIN) :
                   (w_raw > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : w_raw;
    assign h_eff = (h_raw < DW'(WIN)) ? DW'(WIN) :
                   (h_raw > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : h_raw;

    assign c_ext = DW'(col_reg);
    assign r_ext = DW'(row_reg);
    assign c_m1  = c_ext - 1'b1;
    assign r_m1  = r_ext - 1'b1;

    assign accept     = in_valid && !in_stall;
    assign has_result = (r_ext >= DW'(2)) && (c_ext >= DW'(2))
                        && (r_ext < h_eff) && (c_ext < w_eff);
    assign is_last    = (r_ext == h_eff - 1'b1) && (c_ext == w_eff - 1'b1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (c_ext + 1'b1 >= w_eff)
        begin
            col_next = '0;
            row_next = (r_ext + 1'b1 >= h_eff) ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_result_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                s1_result_reg <= has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= pixel;
            s1_addr_reg <= col_reg;
            s1_row_reg  <= r_m1[COORD_W-1:0];
            s1_col_reg  <= c_m1[COORD_W-1:0];
            s1_last_reg <= is_last;
        end
    end

    // Read at the new column, write back in the following cycle. Two beats in a row
    // never share a column since the width is at least three.
    conv3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata ({up_one, s1_px_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (line_rd)
    );

    // ------------------------------------------------ stage 1: shift window
    assign up_two = line_rd[2*PIX_W-1:PIX_W];
    assign up_one = line_rd[PIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_result_reg;
            if (s1_valid_reg)
            begin
                for (int i = 0; i < WIN; i++)
                begin
                    for (int j = 0; j < WIN - 1; j++)
                    begin
                        win_reg[i*WIN + j] <= win_reg[i*WIN + j + 1];
                    end
                end
                win_reg[WIN - 1]       <= up_two;
                win_reg[2*WIN - 1]     <= up_one;
                win_reg[WIN*WIN - 1]   <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // --------------------------------------------------- stage 2: multiply
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                prod[i*WIN + j] = $signed(mask_rows_reg[i][j*TAP_W +: TAP_W])
                                  * $signed({1'b0, win_reg[i*WIN + j]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                prod_reg[k] <= prod[k];
            end
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ------------------------------------------- stage 3: sum and magnitude
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            sum = sum + SUM_W'(prod_reg[k]);
        end
        mag = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
    end

    assign push_res.filtered_value = mag[PIX_W-1:0];
    assign push_res.center_row     = s3_row_reg;
    assign push_res.center_col     = s3_col_reg;
    assign push_res.frame_last     = s3_last_reg;

    conv3_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_data (push_res),
        .pop       (!out_stall),
        .head_data (head_bits),
        .not_empty (out_valid),
        .count     (fifo_count)
    );

    // hold input once queued plus in-flight results could fill the FIFO
    assign occupancy = (CNT_W + 1)'(fifo_count)
                       + (CNT_W + 1)'(s1_valid_reg && s1_result_reg)
                       + (CNT_W + 1)'(s2_valid_reg)
                       + (CNT_W + 1)'(s3_valid_reg);
    assign in_stall  = (occupancy >= (CNT_W + 1)'(OUT_FIFO_DEPTH));

    assign head_res       = head_bits;
    assign filtered_value = head_res.filtered_value;
    assign center_row     = head_res.center_row;
    assign center_col     = head_res.center_col;
    assign frame_last     = head_res.frame_last;

endmodule

[design/conv3_ram.sv]
module conv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/conv3_fifo.sv]
module conv3_fifo #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           head_data,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign head_data = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/conv3_check.sv]
module conv3_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [conv3_pkg::PIX_W-1:0]   filtered_value,
    input logic [conv3_pkg::COORD_W-1:0] center_row,
    input logic [conv3_pkg::COORD_W-1:0] center_col,
    input logic                          frame_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filtered_value)
            && $stable(center_row) && $stable(center_col) && $stable(frame_last))
        else $error("result beat changed while stalled");

    // input backpressure only comes from a queue that has something to show
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output queue");

    // results are only for interior centres
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (center_row != '0) && (center_col != '0))
        else $error("result for a border centre");

    // whenever input is held off, at least one result is waiting
    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |-> out_valid)
        else $error("input held with no result waiting");

endmodule

bind image_convolution_3x3 conv3_check u_conv3_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .center_row     (center_row),
    .center_col     (center_col),
    .frame_last     (frame_last)
);
